// File: sv/streaming_matrix_multiply_macros.svh
// Assertion macros shared by the RTL.
`ifndef STREAMING_MATRIX_MULTIPLY_MACROS_SVH
`define STREAMING_MATRIX_MULTIPLY_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SMM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/smm_pkg.sv
package smm_pkg;

    localparam int ELEM_W     = 16;
    localparam int ROW_W      = 16;
    localparam int COL_W      = 4;
    localparam int SUM_W      = 48;
    localparam int PROD_W     = 2 * ELEM_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int INNER_REG_W = 5;
    localparam int COLS_REG_W  = 5;

    localparam logic [ROW_W-1:0]       ROW_COUNT_RST  = 16'd16;
    localparam logic [INNER_REG_W-1:0] INNER_SIZE_RST = 5'd16;
    localparam logic [COLS_REG_W-1:0]  OUT_COLS_RST   = 5'd16;

    // Element kinds.
    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_COMPUTE = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_COUNT  = 2'd0,
        CFG_INNER_SIZE = 2'd1,
        CFG_OUT_COLS   = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_state;

    typedef struct packed {
        logic                     kind;
        logic signed [ELEM_W-1:0] elem_value;
    } t_in_req;

    typedef struct packed {
        logic [ROW_W-1:0]        out_row;
        logic [COL_W-1:0]        out_col;
        logic signed [SUM_W-1:0] sum_value;
        logic                    row_end;
        logic                    matrix_end;
    } t_out_res;

endpackage

// File: sv/streaming_matrix_multiply.sv
// Streaming matrix multiply, C = A * B, signed Q8.8 elements, exact Q32.16 sums.
// Input channel (i_valid / o_stall / i_req): a request with kind LOAD writes the
//   next element of B, row-major, into the B memory; kind COMPUTE streams the
//   next element of A, row-major. Load B completely before streaming A.
// Output channel (o_valid / i_stall / o_res): after the last A element of a row,
//   out_cols results leave in column order; row_end flags the last column and
//   matrix_end the last column of the last row.
// Config port: i_cfg_we / i_cfg_idx / i_cfg_data, write only while idle.
// Operation: a B load is written into the B memory as it is accepted. For an
//   A element, one shared multiply-accumulate walks the B row and the
//   accumulator memory, one column per cycle, then drains its 2-stage pipe.
//   Row-end results leave one by one through the single accumulator read port.
// The input stalls while an element is in flight; a finished result waits in
//   the output register while the next request is taken. An output stall holds
//   the emission sequence.
// Reset: registers return to 16/16/16, positions to zero, accumulators read as
//   zero through per-column valid bits; no clearing pass is needed.
`include "streaming_matrix_multiply_macros.svh"

module streaming_matrix_multiply #(
    parameter int MAX_INNER = 16,
    parameter int MAX_COLS  = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  smm_pkg::t_in_req                   i_req,
    output logic                               o_valid,
    input  logic                               i_stall,
    output smm_pkg::t_out_res                  o_res,
    input  logic                               i_cfg_we,
    input  logic [smm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [smm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int B_DEPTH     = MAX_INNER * MAX_COLS;
    localparam int B_ADDR_W    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
    localparam int I_IDX_W     = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
    localparam int C_IDX_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int INNER_CNT_W = $clog2(MAX_INNER + 1);
    localparam int COLS_CNT_W  = $clog2(MAX_COLS + 1);
    localparam int ACC_W       = smm_pkg::PROD_W + $clog2(MAX_INNER + 1);

    // ---------------------------------------------------------------
    // Configuration registers and their effective (clamped) values
    // ---------------------------------------------------------------
    logic [smm_pkg::ROW_W-1:0]       r_row_count;
    logic [smm_pkg::INNER_REG_W-1:0] r_inner_size;
    logic [smm_pkg::COLS_REG_W-1:0]  r_out_cols;

    logic [smm_pkg::ROW_W-1:0] eff_rows;
    logic [INNER_CNT_W-1:0]    eff_inner;
    logic [COLS_CNT_W-1:0]     eff_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count  <= smm_pkg::ROW_COUNT_RST;
            r_inner_size <= smm_pkg::INNER_SIZE_RST;
            r_out_cols   <= smm_pkg::OUT_COLS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                smm_pkg::CFG_ROW_COUNT:  r_row_count  <= i_cfg_data[smm_pkg::ROW_W-1:0];
                smm_pkg::CFG_INNER_SIZE: r_inner_size <= i_cfg_data[smm_pkg::INNER_REG_W-1:0];
                smm_pkg::CFG_OUT_COLS:   r_out_cols   <= i_cfg_data[smm_pkg::COLS_REG_W-1:0];
                default: ; // unmapped index: drop the write
            endcase
        end
    end

    // Zero acts as one; anything above the build limit acts as the limit.
    always_comb begin
        eff_rows = (r_row_count == '0) ? smm_pkg::ROW_W'(1) : r_row_count;
        if (r_inner_size == '0)
            eff_inner = INNER_CNT_W'(1);
        else if (32'(r_inner_size) > MAX_INNER)
            eff_inner = INNER_CNT_W'(MAX_INNER);
        else
            eff_inner = INNER_CNT_W'(r_inner_size);
        if (r_out_cols == '0)
            eff_cols = COLS_CNT_W'(1);
        else if (32'(r_out_cols) > MAX_COLS)
            eff_cols = COLS_CNT_W'(MAX_COLS);
        else
            eff_cols = COLS_CNT_W'(r_out_cols);
    end

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    smm_pkg::t_state r_state, n_state;

    logic [B_ADDR_W-1:0]       r_b_load_pos;
    logic [I_IDX_W-1:0]        r_a_col_pos;
    logic [smm_pkg::ROW_W-1:0] r_row_pos;
    logic [C_IDX_W-1:0]        r_j;        // MAC issue column
    logic [C_IDX_W-1:0]        r_k;        // emission column
    logic                      r_last;     // current element ends its row
    logic [B_ADDR_W-1:0]       r_base;     // B row base for current element
    logic signed [smm_pkg::ELEM_W-1:0] r_x;
    logic [MAX_COLS-1:0]       r_acc_vld;

    logic in_accept;
    logic mac_issue;
    logic emit_rd_go;
    logic emit_ld;
    logic j_last;
    logic k_last;
    logic last_row;
    logic a_last;
    logic b_load_last;

    // Pipeline
    logic                      r_p1_vld, r_p2_vld;
    logic [C_IDX_W-1:0]        r_p1_col, r_p2_col;
    logic                      r_p1_accv;
    logic signed [ACC_W-1:0]   r_p2_acc;
    logic signed [smm_pkg::PROD_W-1:0] r_prod;
    logic                      r_em_vld;

    // Memories and their read registers
    logic signed [smm_pkg::ELEM_W-1:0] b_mem [B_DEPTH];
    logic signed [ACC_W-1:0]           acc_mem [MAX_COLS];
    logic signed [smm_pkg::ELEM_W-1:0] r_b_rd;
    logic signed [ACC_W-1:0]           r_acc_rd;
    logic [B_ADDR_W-1:0]               b_rd_addr;
    logic [C_IDX_W-1:0]                acc_rd_addr;
    logic signed [ACC_W-1:0]           acc_sum;

    smm_pkg::t_out_res r_o_res;
    logic              r_o_valid;

    assign in_accept   = i_valid && !o_stall;
    assign j_last      = (32'(r_j) + 32'd1 >= 32'(eff_cols));
    assign k_last      = (32'(r_k) + 32'd1 >= 32'(eff_cols));
    assign last_row    = (32'(r_row_pos) + 32'd1 >= 32'(eff_rows));
    assign a_last      = (32'(r_a_col_pos) + 32'd1 >= 32'(eff_inner));
    assign b_load_last = (32'(r_b_load_pos) + 32'd1 >= 32'(eff_inner) * 32'(eff_cols));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            smm_pkg::ST_IDLE: begin
                if (in_accept && i_req.kind == smm_pkg::KIND_COMPUTE)
                    n_state = smm_pkg::ST_MAC;
            end
            smm_pkg::ST_MAC: begin
                if (j_last)
                    n_state = smm_pkg::ST_DRAIN;
            end
            smm_pkg::ST_DRAIN: begin
                // Last write-back retires at this edge once stage 1 is empty.
                if (!r_p1_vld)
                    n_state = r_last ? smm_pkg::ST_EMIT_RD : smm_pkg::ST_IDLE;
            end
            smm_pkg::ST_EMIT_RD: begin
                if (emit_rd_go)
                    n_state = smm_pkg::ST_EMIT_LD;
            end
            smm_pkg::ST_EMIT_LD: begin
                n_state = k_last ? smm_pkg::ST_IDLE : smm_pkg::ST_EMIT_RD;
            end
            default: n_state = smm_pkg::ST_IDLE;
        endcase
    end

    // State-decoded controls
    always_comb begin
        o_stall    = 1'b1;
        mac_issue  = 1'b0;
        emit_rd_go = 1'b0;
        emit_ld    = 1'b0;
        unique case (r_state)
            smm_pkg::ST_IDLE:    o_stall = 1'b0;
            smm_pkg::ST_MAC:     mac_issue = 1'b1;
            smm_pkg::ST_DRAIN:   ;
            // Issue a read only if the output register is free by the next edge.
            smm_pkg::ST_EMIT_RD: emit_rd_go = !r_o_valid || !i_stall;
            smm_pkg::ST_EMIT_LD: emit_ld = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= smm_pkg::ST_IDLE;
            r_b_load_pos <= '0;
            r_a_col_pos  <= '0;
            r_row_pos    <= '0;
            r_j          <= '0;
            r_k          <= '0;
            r_last       <= 1'b0;
            r_acc_vld    <= '0;
        end else begin
            r_state <= n_state;
            if (in_accept) begin
                if (i_req.kind == smm_pkg::KIND_LOAD) begin
                    // Advance the B fill pointer, wrap after the last entry.
                    r_b_load_pos <= b_load_last ? '0 : r_b_load_pos + B_ADDR_W'(1);
                end else begin
                    // Row start: drop all accumulators at once.
                    if (r_a_col_pos == '0)
                        r_acc_vld <= '0;
                    r_last      <= a_last;
                    r_a_col_pos <= a_last ? '0 : r_a_col_pos + I_IDX_W'(1);
                    r_j         <= '0;
                    r_k         <= '0;
                end
            end
            if (mac_issue)
                r_j <= r_j + C_IDX_W'(1);
            if (r_p2_vld)
                r_acc_vld[r_p2_col] <= 1'b1;
            if (emit_ld) begin
                r_k <= r_k + C_IDX_W'(1);
                if (k_last)
                    r_row_pos <= last_row ? '0 : r_row_pos + smm_pkg::ROW_W'(1);
            end
        end
    end

    // Latch the A element and its B row base.
    always_ff @(posedge i_clk) begin
        if (in_accept && i_req.kind == smm_pkg::KIND_COMPUTE) begin
            r_x    <= i_req.elem_value;
            r_base <= B_ADDR_W'(32'(r_a_col_pos) * 32'(eff_cols));
        end
    end

    // ---------------------------------------------------------------
    // B memory: one write (load), one read (MAC issue)
    // ---------------------------------------------------------------
    assign b_rd_addr = r_base + B_ADDR_W'(r_j);

    always_ff @(posedge i_clk) begin
        if (in_accept && i_req.kind == smm_pkg::KIND_LOAD)
            b_mem[r_b_load_pos] <= i_req.elem_value;
        r_b_rd <= b_mem[b_rd_addr];
    end

    // ---------------------------------------------------------------
    // Accumulator memory: read-modify-write, one column per cycle.
    // Each column is touched once per element and the pipe drains before
    // the next element enters, so no forwarding path is needed.
    // ---------------------------------------------------------------
    assign acc_rd_addr = (r_state == smm_pkg::ST_EMIT_RD) ? r_k : r_j;
    assign acc_sum     = r_p2_acc + ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (r_p2_vld)
            acc_mem[r_p2_col] <= acc_sum;
        r_acc_rd <= acc_mem[acc_rd_addr];
    end

    // Stage 1: memory data arrives, multiply. Stage 2: add and write back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
        end else begin
            r_p1_vld <= mac_issue;
            r_p2_vld <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_col  <= r_j;
        r_p1_accv <= r_acc_vld[r_j];
        r_p2_col  <= r_p1_col;
        r_p2_acc  <= r_p1_accv ? r_acc_rd : '0;
        r_prod    <= r_x * r_b_rd;
        r_em_vld  <= r_acc_vld[r_k];
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (emit_ld) begin
            r_o_valid <= 1'b1;
        end else if (r_o_valid && !i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_ld) begin
            r_o_res.out_row    <= r_row_pos;
            r_o_res.out_col    <= smm_pkg::COL_W'(r_k);
            // Sign-extend the sum to the output width.
            r_o_res.sum_value  <= r_em_vld ? smm_pkg::SUM_W'(r_acc_rd) : '0;
            r_o_res.row_end    <= k_last;
            r_o_res.matrix_end <= k_last && last_row;
        end
    end

    assign o_valid = r_o_valid;
    assign o_res   = r_o_res;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `SMM_ASSERT_IMPLY(a_no_overwrite, i_clk, i_rst_n, emit_ld, !r_o_valid,
        "output register overwritten while holding a result")
    `SMM_ASSERT_IMPLY(a_accept_drained, i_clk, i_rst_n, in_accept,
        !r_p1_vld && !r_p2_vld, "request accepted with MAC pipe busy")
    `SMM_ASSERT_IMPLY(a_wb_in_mac, i_clk, i_rst_n, r_p2_vld,
        r_state == smm_pkg::ST_MAC || r_state == smm_pkg::ST_DRAIN,
        "accumulator write-back outside the MAC pass")
    `SMM_ASSERT_NEXT(a_emit_after_drain, i_clk, i_rst_n,
        r_state == smm_pkg::ST_DRAIN && !r_p1_vld && r_last,
        r_state == smm_pkg::ST_EMIT_RD && !r_p2_vld,
        "emission started before accumulators settled")

endmodule

// File: sim/streaming_matrix_multiply_tb.sv
module streaming_matrix_multiply_tb;

    localparam int NUM_ITEMS      = 430;
    localparam int SETTLE_CYCLES  = 40;     // longest element: every column plus the pipe drain, padded
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_REPORTS    = 10;
    localparam int K_MAX          = 16;
    localparam int N_MAX          = 16;
    localparam int B_DEPTH        = K_MAX * N_MAX;

    // DUT ports; the driven inputs are known from time zero.
    logic                           i_clk      = 1'b0;
    logic                           i_rst_n    = 1'b0;
    logic                           i_valid    = 1'b0;
    logic                           o_stall;
    smm_pkg::t_in_req               i_req      = '0;
    logic                           o_valid;
    logic                           i_stall    = 1'b0;
    smm_pkg::t_out_res              o_res;
    logic                           i_cfg_we   = 1'b0;
    logic [smm_pkg::CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [smm_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    streaming_matrix_multiply u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: register copies, B store, column sums, positions.
    // ------------------------------------------------------------------
    logic [smm_pkg::ROW_W-1:0]         rows_cfg;
    logic [smm_pkg::INNER_REG_W-1:0]   inner_cfg;
    logic [smm_pkg::COLS_REG_W-1:0]    cols_cfg;
    logic signed [smm_pkg::ELEM_W-1:0] b_mem [B_DEPTH];
    logic signed [smm_pkg::SUM_W-1:0]  col_acc [N_MAX];
    int unsigned                       b_wr_pos;
    int unsigned                       a_pos;
    int unsigned                       row_idx;
    smm_pkg::t_out_res                 c_due [$];     // result elements still owed by the block

    // Stimulus side: pending requests and a shadow of the load/compute positions,
    // used only to keep compute requests off B entries that were never loaded.
    smm_pkg::t_in_req elem_queue [$];
    bit               b_written [B_DEPTH];
    int unsigned      g_k = K_MAX;
    int unsigned      g_n = N_MAX;
    int unsigned      g_bpos = 0;
    int unsigned      g_apos = 0;

    // Bookkeeping.
    int  items_queued = 0;
    int  items_accepted = 0;
    int  results_seen = 0;
    int  mismatches = 0;
    int  settings_applied = 0;
    int  idle_cycles = 0;
    bit  no_idle = 1'b0;
    logic req_taken = 1'b0;
    logic res_taken = 1'b0;
    int  send_gap = 0;
    int  stall_left = 0;

    // Zero acts as one; anything above the hardware maximum acts as the maximum.
    function automatic int unsigned clamp_dim(logic [4:0] v, int unsigned top);
        if (v == 0) return 1;
        return (v > top) ? top : int'(v);
    endfunction

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 6);
    endfunction

    // Advance the predicted block by one accepted request; queue the row of
    // sums when a compute request closes an A row.
    function automatic void accumulate_element(smm_pkg::t_in_req req);
        int unsigned                       k;
        int unsigned                       n;
        int unsigned                       m;
        int unsigned                       j;
        logic signed [smm_pkg::PROD_W-1:0] prod;
        logic                              last_row;
        smm_pkg::t_out_res                 res;
        k = clamp_dim(inner_cfg, K_MAX);
        n = clamp_dim(cols_cfg, N_MAX);
        m = (rows_cfg == 0) ? 1 : rows_cfg;
        if (req.kind == smm_pkg::KIND_LOAD) begin
            b_mem[b_wr_pos] = req.elem_value;
            b_wr_pos = (b_wr_pos + 1 >= k * n) ? 0 : b_wr_pos + 1;
        end else begin
            if (a_pos == 0) begin
                for (j = 0; j < N_MAX; j++) col_acc[j] = '0;
            end
            for (j = 0; j < n; j++) begin
                prod = $signed(req.elem_value) * $signed(b_mem[a_pos * n + j]);
                col_acc[j] = col_acc[j] + prod;
            end
            if (a_pos + 1 < k) begin
                a_pos++;
            end else begin
                last_row = (row_idx + 1 >= m);
                for (j = 0; j < n; j++) begin
                    res.out_row    = row_idx[smm_pkg::ROW_W-1:0];
                    res.out_col    = j[smm_pkg::COL_W-1:0];
                    res.sum_value  = col_acc[j];
                    res.row_end    = (j + 1 == n);
                    res.matrix_end = (j + 1 == n) && last_row;
                    c_due.push_back(res);
                end
                a_pos   = 0;
                row_idx = last_row ? 0 : row_idx + 1;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: sample both channels and the config port at the rising edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        smm_pkg::t_out_res want;
        req_taken <= i_rst_n && i_valid && !o_stall;
        res_taken <= i_rst_n && o_valid && !i_stall;
        if (!i_rst_n) begin
            rows_cfg    = smm_pkg::ROW_COUNT_RST;
            inner_cfg   = smm_pkg::INNER_SIZE_RST;
            cols_cfg    = smm_pkg::OUT_COLS_RST;
            b_wr_pos    = 0;
            a_pos       = 0;
            row_idx     = 0;
            idle_cycles = 0;
            for (int j = 0; j < N_MAX; j++) col_acc[j] = '0;
        end else begin
            // Mirror register writes; a write touches no position.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    smm_pkg::CFG_ROW_COUNT:  rows_cfg  = i_cfg_data[smm_pkg::ROW_W-1:0];
                    smm_pkg::CFG_INNER_SIZE: inner_cfg = i_cfg_data[smm_pkg::INNER_REG_W-1:0];
                    smm_pkg::CFG_OUT_COLS:   cols_cfg  = i_cfg_data[smm_pkg::COLS_REG_W-1:0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                accumulate_element(i_req);
                items_accepted++;
            end
            // Check each result against the oldest owed sum.
            if (o_valid && !i_stall) begin
                results_seen++;
                if (c_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"unexpected result: row %0d col %0d sum %0d",
                                  " row_end %b matrix_end %b"},
                                 o_res.out_row, o_res.out_col, o_res.sum_value,
                                 o_res.row_end, o_res.matrix_end);
                end else begin
                    want = c_due.pop_front();
                    if (o_res.out_row !== want.out_row || o_res.out_col !== want.out_col ||
                        o_res.sum_value !== want.sum_value || o_res.row_end !== want.row_end ||
                        o_res.matrix_end !== want.matrix_end) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display({"result %0d expected: row %0d col %0d sum %0d",
                                      " row_end %b matrix_end %b"},
                                     results_seen, want.out_row, want.out_col,
                                     want.sum_value, want.row_end, want.matrix_end);
                            $display({"result %0d actual:   row %0d col %0d sum %0d",
                                      " row_end %b matrix_end %b"},
                                     results_seen, o_res.out_row, o_res.out_col,
                                     o_res.sum_value, o_res.row_end, o_res.matrix_end);
                        end
                    end
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // ------------------------------------------------------------------
    // Driver: present the next request at the falling edge once the previous
    // one was taken and its random gap has run out. Hold the payload while stalled.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_valid || req_taken) begin
            if (send_gap != 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (elem_queue.size() != 0) begin
                i_req    <= elem_queue.pop_front();
                i_valid  <= 1'b1;
                send_gap = draw_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result side: draw a stall run after every taken result.
    always @(negedge i_clk) begin
        if (res_taken) stall_left = draw_gap();
        if (stall_left != 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // Queue one request. Turn a compute request into a load when its B row
    // has an entry that was never loaded.
    function automatic void queue_elem(logic kind, logic [smm_pkg::ELEM_W-1:0] value);
        smm_pkg::t_in_req r;
        int unsigned      j;
        if (kind == smm_pkg::KIND_COMPUTE) begin
            for (j = 0; j < g_n; j++)
                if (!b_written[g_apos * g_n + j]) kind = smm_pkg::KIND_LOAD;
        end
        r.kind       = kind;
        r.elem_value = value;
        if (kind == smm_pkg::KIND_LOAD) begin
            b_written[g_bpos] = 1'b1;
            g_bpos = (g_bpos + 1 >= g_k * g_n) ? 0 : g_bpos + 1;
        end else begin
            g_apos = (g_apos + 1 < g_k) ? g_apos + 1 : 0;
        end
        elem_queue.push_back(r);
        items_queued++;
    endfunction

    // Bias toward the extremes of the Q8.8 range.
    function automatic logic [smm_pkg::ELEM_W-1:0] rand_elem();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return smm_pkg::ELEM_W'($urandom);
        endcase
    endfunction

    // Write all three registers on consecutive cycles.
    task automatic write_dims(logic [smm_pkg::CFG_DATA_W-1:0] rows,
                              logic [smm_pkg::CFG_DATA_W-1:0] inner,
                              logic [smm_pkg::CFG_DATA_W-1:0] cols);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= smm_pkg::CFG_ROW_COUNT;
        i_cfg_data <= rows;
        @(negedge i_clk);
        i_cfg_idx  <= smm_pkg::CFG_INNER_SIZE;
        i_cfg_data <= inner;
        @(negedge i_clk);
        i_cfg_idx  <= smm_pkg::CFG_OUT_COLS;
        i_cfg_data <= cols;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        g_k = clamp_dim(inner[smm_pkg::INNER_REG_W-1:0], K_MAX);
        g_n = clamp_dim(cols[smm_pkg::COLS_REG_W-1:0], N_MAX);
        settings_applied++;
    endtask

    // Hold off until every request is taken and every owed sum has come out,
    // then let a possible element without results finish.
    task automatic drain_block();
        while (items_accepted != items_queued || c_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // One matrix: optionally reload B, then whole A rows with random content.
    // Sprinkle stray requests of either kind, which also overwrite B mid-row.
    task automatic stream_matrix(int unsigned n_rows, bit reload);
        int unsigned r;
        int unsigned e;
        if (reload) begin
            for (e = 0; e < g_k * g_n; e++) queue_elem(smm_pkg::KIND_LOAD, rand_elem());
        end
        for (r = 0; r < n_rows; r++) begin
            for (e = 0; e < g_k; e++) begin
                if ($urandom_range(0, 19) == 0)
                    queue_elem(logic'($urandom_range(0, 1)), rand_elem());
                queue_elem(smm_pkg::KIND_COMPUTE, rand_elem());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Run sequence.
    // ------------------------------------------------------------------
    initial begin : stimulus
        int                             phase;
        int                             target;
        logic [smm_pkg::CFG_DATA_W-1:0] rows_w;
        logic [smm_pkg::CFG_DATA_W-1:0] inner_w;
        logic [smm_pkg::CFG_DATA_W-1:0] cols_w;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: a 2x2 by 2x3 product with extreme operands, both row flags.
        write_dims(16'd2, 16'd2, 16'd3);
        queue_elem(smm_pkg::KIND_LOAD, 16'h8000);
        queue_elem(smm_pkg::KIND_LOAD, 16'h7FFF);
        queue_elem(smm_pkg::KIND_LOAD, 16'h0000);
        queue_elem(smm_pkg::KIND_LOAD, 16'hFFFF);
        queue_elem(smm_pkg::KIND_LOAD, 16'h0001);
        queue_elem(smm_pkg::KIND_LOAD, 16'h8000);
        queue_elem(smm_pkg::KIND_COMPUTE, 16'h8000);
        queue_elem(smm_pkg::KIND_COMPUTE, 16'h8000);
        queue_elem(smm_pkg::KIND_COMPUTE, 16'h7FFF);
        queue_elem(smm_pkg::KIND_COMPUTE, 16'hFFFF);
        // B load in the middle of an A row overwrites entry 0, the row carries on.
        queue_elem(smm_pkg::KIND_COMPUTE, 16'h0100);
        queue_elem(smm_pkg::KIND_LOAD, 16'h1234);
        queue_elem(smm_pkg::KIND_COMPUTE, 16'h8000);
        drain_block();
        // Shrink inner_size under a half-finished row: the next element closes it.
        queue_elem(smm_pkg::KIND_COMPUTE, 16'h7FFF);
        drain_block();
        write_dims(16'd2, 16'd1, 16'd3);
        queue_elem(smm_pkg::KIND_COMPUTE, 16'h0001);
        drain_block();
        // Zero in every register acts as one; set the unused upper data bits.
        write_dims(16'h0000, 16'hFFE0, 16'hFFE0);
        queue_elem(smm_pkg::KIND_LOAD, 16'h8000);
        queue_elem(smm_pkg::KIND_COMPUTE, 16'h8000);
        queue_elem(smm_pkg::KIND_COMPUTE, 16'h7FFF);
        drain_block();

        // Random matrices: extremes first, then mostly small shapes.
        target = items_queued + NUM_ITEMS;
        phase  = 0;
        while (items_queued < target) begin
            case (phase)
                0: begin rows_w = 16'hFFFF; inner_w = 16'h0011; cols_w = 16'h0001; end
                1: begin rows_w = 16'h0001; inner_w = 16'hFFE1; cols_w = 16'h001F; end
                2: begin rows_w = 16'h0002; inner_w = 16'h0010; cols_w = 16'h0010; end
                default: begin
                    rows_w  = ($urandom_range(0, 4) == 0)
                              ? smm_pkg::CFG_DATA_W'($urandom)
                              : smm_pkg::CFG_DATA_W'($urandom_range(0, 4));
                    inner_w = ($urandom_range(0, 3) == 0)
                              ? smm_pkg::CFG_DATA_W'($urandom)
                              : smm_pkg::CFG_DATA_W'($urandom_range(1, 6));
                    cols_w  = ($urandom_range(0, 3) == 0)
                              ? smm_pkg::CFG_DATA_W'($urandom)
                              : smm_pkg::CFG_DATA_W'($urandom_range(1, 6));
                end
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            write_dims(rows_w, inner_w, cols_w);
            stream_matrix((phase == 2) ? 1 : $urandom_range(1, 5),
                          (phase < 3) || ($urandom_range(0, 3) != 0));
            // Pause the sender here until every owed sum is out.
            drain_block();
            phase++;
        end

        $display("Run covered %0d requests and %0d result elements over %0d register settings",
                 items_accepted, results_seen, settings_applied);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d mismatching or unexpected results", mismatches);
            $display("Mismatches found");
        end
        $finish;
    end

    // Give up when the block goes quiet for too long.
    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) @(negedge i_clk);
        $display("timeout after %0d cycles without a handshake", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/smm_pkg.sv
sv/streaming_matrix_multiply.sv
sim/streaming_matrix_multiply_tb.sv
